/* src/smfp_pkg.sv */
package smfp_pkg;

	localparam int unsigned VARLEN_MAX_DEF = 4;

	localparam logic [31:0] MAGIC_MTHD = 32'h4D54_6864;
	localparam logic [31:0] MAGIC_MTRK = 32'h4D54_726B;
	localparam logic [31:0] HEADER_LEN = 32'd6;

	localparam logic [7:0] STATUS_META    = 8'hFF;
	localparam logic [7:0] STATUS_SYSEX   = 8'hF0;
	localparam logic [7:0] STATUS_SYSEX_E = 8'hF7;

	localparam logic [2:0] KIND_HEADER  = 3'd0;
	localparam logic [2:0] KIND_CHANNEL = 3'd1;
	localparam logic [2:0] KIND_META    = 3'd2;
	localparam logic [2:0] KIND_SYSEX   = 3'd3;
	localparam logic [2:0] KIND_EMPTY   = 3'd4;
	localparam logic [2:0] KIND_ERROR   = 3'd5;

	localparam logic [3:0] ERR_NONE       = 4'd0;
	localparam logic [3:0] ERR_BAD_MTHD   = 4'd1;
	localparam logic [3:0] ERR_HDR_LEN    = 4'd2;
	localparam logic [3:0] ERR_FORMAT2    = 4'd3;
	localparam logic [3:0] ERR_BAD_FORMAT = 4'd4;
	localparam logic [3:0] ERR_SMPTE      = 4'd5;
	localparam logic [3:0] ERR_BAD_MTRK   = 4'd6;
	localparam logic [3:0] ERR_BAD_STATUS = 4'd7;
	localparam logic [3:0] ERR_VARLEN     = 4'd8;
	localparam logic [3:0] ERR_OVERRUN    = 4'd9;

	typedef enum logic [15:0] {
		PH_MAGIC     = 16'b0000_0000_0000_0001,
		PH_HLEN      = 16'b0000_0000_0000_0010,
		PH_FMT       = 16'b0000_0000_0000_0100,
		PH_NTRK      = 16'b0000_0000_0000_1000,
		PH_DIV       = 16'b0000_0000_0001_0000,
		PH_TMAGIC    = 16'b0000_0000_0010_0000,
		PH_TLEN      = 16'b0000_0000_0100_0000,
		PH_DELTA     = 16'b0000_0000_1000_0000,
		PH_STATUS    = 16'b0000_0001_0000_0000,
		PH_META_TYPE = 16'b0000_0010_0000_0000,
		PH_BODY_LEN  = 16'b0000_0100_0000_0000,
		PH_BODY      = 16'b0000_1000_0000_0000,
		PH_DATA1     = 16'b0001_0000_0000_0000,
		PH_DATA2     = 16'b0010_0000_0000_0000,
		PH_DONE      = 16'b0100_0000_0000_0000,
		PH_HALT      = 16'b1000_0000_0000_0000
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       new_file;
	} byte_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [27:0] delta_time;
		logic [7:0]  status_byte;
		logic [7:0]  first_data;
		logic [7:0]  second_data;
		logic [27:0] body_length;
		logic        file_format;
		logic [15:0] track_count;
		logic [14:0] ticks_per_quarter;
		logic [3:0]  error_code;
		logic        track_end;
		logic [15:0] track_index;
	} event_t;

endpackage

/* src/smfp_core.sv */
module smfp_core import smfp_pkg::*; #(
	parameter int unsigned MAX_VARLEN_BYTES = VARLEN_MAX_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   step,
	input  byte_t  item,
	output logic   res_valid,
	output event_t res
);

	localparam int unsigned VLW = $clog2(MAX_VARLEN_BYTES + 1);
	localparam logic [VLW-1:0] VL_LIMIT = VLW'(MAX_VARLEN_BYTES);

	phase_t         phase_q, phase_d, cur_phase;
	logic [2:0]     fbc_q, fbc_d, cur_fbc;
	logic [31:0]    asm_q, asm_d, cur_asm;
	logic [31:0]    tbl_q, tbl_d, cur_tbl;
	logic [15:0]    tot_q, tot_d, cur_tot;
	logic [15:0]    ct_q, ct_d, cur_ct;
	logic [27:0]    da_q, da_d, cur_da;
	logic [VLW-1:0] vb_q, vb_d, cur_vb;
	logic [7:0]     hs_q, hs_d, cur_hs;
	logic [7:0]     hd_q, hd_d, cur_hd;
	logic [27:0]    bl_q, bl_d, cur_bl;
	logic [27:0]    bt_q, bt_d, cur_bt;

	logic [7:0]     b;
	logic [31:0]    asm_c;
	logic [2:0]     fbc_c;
	logic           full4, full2;
	logic [VLW-1:0] vb_c;
	logic           vl_over;
	logic [31:0]    tbl_c;
	logic [15:0]    ct_n;
	logic           is_evt;

	assign b = item.data_byte;

	always_comb begin
		if (item.new_file) begin
			cur_phase = PH_MAGIC;
			cur_fbc   = '0;
			cur_asm   = '0;
			cur_tbl   = '0;
			cur_tot   = '0;
			cur_ct    = '0;
			cur_da    = '0;
			cur_vb    = '0;
			cur_hs    = '0;
			cur_hd    = '0;
			cur_bl    = '0;
			cur_bt    = '0;
		end else begin
			cur_phase = phase_q;
			cur_fbc   = fbc_q;
			cur_asm   = asm_q;
			cur_tbl   = tbl_q;
			cur_tot   = tot_q;
			cur_ct    = ct_q;
			cur_da    = da_q;
			cur_vb    = vb_q;
			cur_hs    = hs_q;
			cur_hd    = hd_q;
			cur_bl    = bl_q;
			cur_bt    = bt_q;
		end
	end

	assign asm_c   = {cur_asm[23:0], b};
	assign fbc_c   = cur_fbc + 3'd1;
	assign full4   = (fbc_c >= 3'd4);
	assign full2   = (fbc_c >= 3'd2);
	assign vb_c    = cur_vb + VLW'(1);
	assign vl_over = b[7] && (vb_c >= VL_LIMIT);
	assign tbl_c   = cur_tbl - 32'd1;
	assign ct_n    = cur_ct + 16'd1;
	assign is_evt  = (cur_phase inside {PH_DELTA, PH_STATUS, PH_META_TYPE, PH_BODY_LEN,
		PH_BODY, PH_DATA1, PH_DATA2});

	always_comb begin
		logic       failed;
		logic [3:0] err;
		logic       done;
		logic [7:0] second;

		failed    = 1'b0;
		err       = ERR_NONE;
		done      = 1'b0;
		second    = '0;
		res       = '0;
		res_valid = 1'b0;
		phase_d   = cur_phase;
		fbc_d     = cur_fbc;
		asm_d     = cur_asm;
		tbl_d     = cur_tbl;
		tot_d     = cur_tot;
		ct_d      = cur_ct;
		da_d      = cur_da;
		vb_d      = cur_vb;
		hs_d      = cur_hs;
		hd_d      = cur_hd;
		bl_d      = cur_bl;
		bt_d      = cur_bt;

		if (is_evt) begin
			tbl_d = tbl_c;
		end

		unique case (cur_phase)
			PH_MAGIC: begin
				asm_d = asm_c;
				fbc_d = full4 ? 3'd0 : fbc_c;
				if (full4) begin
					if (asm_c != MAGIC_MTHD) begin
						failed = 1'b1;
						err    = ERR_BAD_MTHD;
					end else begin
						phase_d = PH_HLEN;
					end
				end
			end
			PH_HLEN: begin
				asm_d = asm_c;
				fbc_d = full4 ? 3'd0 : fbc_c;
				if (full4) begin
					if (asm_c != HEADER_LEN) begin
						failed = 1'b1;
						err    = ERR_HDR_LEN;
					end else begin
						phase_d = PH_FMT;
					end
				end
			end
			PH_FMT: begin
				asm_d = asm_c;
				fbc_d = full2 ? 3'd0 : fbc_c;
				if (full2) begin
					if (asm_c[15:0] == 16'd2) begin
						failed = 1'b1;
						err    = ERR_FORMAT2;
					end else if (asm_c[15:0] > 16'd1) begin
						failed = 1'b1;
						err    = ERR_BAD_FORMAT;
					end else begin
						hd_d    = {7'd0, asm_c[0]};
						phase_d = PH_NTRK;
					end
				end
			end
			PH_NTRK: begin
				asm_d = asm_c;
				fbc_d = full2 ? 3'd0 : fbc_c;
				if (full2) begin
					tot_d   = asm_c[15:0];
					phase_d = PH_DIV;
				end
			end
			PH_DIV: begin
				asm_d = asm_c;
				fbc_d = full2 ? 3'd0 : fbc_c;
				if (full2) begin
					if (asm_c[15]) begin
						failed = 1'b1;
						err    = ERR_SMPTE;
					end else begin
						res_valid             = 1'b1;
						res.kind              = KIND_HEADER;
						res.file_format       = cur_hd[0];
						res.track_count       = cur_tot;
						res.ticks_per_quarter = asm_c[14:0];
						ct_d                  = '0;
						phase_d               = (cur_tot != 16'd0) ? PH_TMAGIC : PH_DONE;
					end
				end
			end
			PH_TMAGIC: begin
				asm_d = asm_c;
				fbc_d = full4 ? 3'd0 : fbc_c;
				if (full4) begin
					if (asm_c != MAGIC_MTRK) begin
						failed = 1'b1;
						err    = ERR_BAD_MTRK;
					end else begin
						phase_d = PH_TLEN;
					end
				end
			end
			PH_TLEN: begin
				asm_d = asm_c;
				fbc_d = full4 ? 3'd0 : fbc_c;
				if (full4) begin
					tbl_d = asm_c;
					da_d  = '0;
					vb_d  = '0;
					if (asm_c == 32'd0) begin
						res_valid       = 1'b1;
						res.kind        = KIND_EMPTY;
						res.track_end   = 1'b1;
						res.track_index = cur_ct;
						ct_d            = ct_n;
						phase_d         = (ct_n >= cur_tot) ? PH_DONE : PH_TMAGIC;
					end else begin
						phase_d = PH_DELTA;
					end
				end
			end
			PH_DELTA: begin
				da_d = {cur_da[20:0], b[6:0]};
				vb_d = vb_c;
				if (!b[7]) begin
					vb_d    = '0;
					phase_d = PH_STATUS;
				end else if (vl_over) begin
					failed = 1'b1;
					err    = ERR_VARLEN;
				end
			end
			PH_STATUS: begin
				hs_d = b;
				hd_d = '0;
				bt_d = '0;
				vb_d = '0;
				if (b == STATUS_META) begin
					phase_d = PH_META_TYPE;
				end else if (b == STATUS_SYSEX || b == STATUS_SYSEX_E) begin
					phase_d = PH_BODY_LEN;
				end else if (b[7] && b[7:4] != 4'hF) begin
					phase_d = PH_DATA1;
				end else begin
					failed = 1'b1;
					err    = ERR_BAD_STATUS;
				end
			end
			PH_META_TYPE: begin
				hd_d    = b;
				phase_d = PH_BODY_LEN;
			end
			PH_BODY_LEN: begin
				bt_d = {cur_bt[20:0], b[6:0]};
				vb_d = vb_c;
				if (!b[7]) begin
					vb_d = '0;
					if (bt_d == 28'd0) begin
						done = 1'b1;
					end else begin
						bl_d    = bt_d;
						phase_d = PH_BODY;
					end
				end else if (vl_over) begin
					failed = 1'b1;
					err    = ERR_VARLEN;
				end
			end
			PH_BODY: begin
				bl_d = cur_bl - 28'd1;
				if (bl_d == 28'd0) begin
					done = 1'b1;
				end
			end
			PH_DATA1: begin
				hd_d = b;
				if (cur_hs[7:4] == 4'hC || cur_hs[7:4] == 4'hD) begin
					done = 1'b1;
				end else begin
					phase_d = PH_DATA2;
				end
			end
			PH_DATA2: begin
				second = b;
				done   = 1'b1;
			end
			default: begin
			end
		endcase

		if (is_evt && !failed && !done && tbl_c == 32'd0) begin
			failed = 1'b1;
			err    = ERR_OVERRUN;
		end

		if (done && !failed) begin
			res_valid = 1'b1;
			if (hs_d == STATUS_META) begin
				res.kind        = KIND_META;
				res.body_length = bt_d;
			end else if (hs_d == STATUS_SYSEX || hs_d == STATUS_SYSEX_E) begin
				res.kind        = KIND_SYSEX;
				res.body_length = bt_d;
			end else begin
				res.kind        = KIND_CHANNEL;
				res.second_data = second;
			end
			res.delta_time  = cur_da;
			res.status_byte = hs_d;
			res.first_data  = hd_d;
			res.track_index = cur_ct;
			res.track_end   = (tbl_c == 32'd0);
			da_d            = '0;
			vb_d            = '0;
			if (tbl_c == 32'd0) begin
				ct_d    = ct_n;
				phase_d = (ct_n >= cur_tot) ? PH_DONE : PH_TMAGIC;
			end else begin
				phase_d = PH_DELTA;
			end
		end

		if (failed) begin
			res             = '0;
			res_valid       = 1'b1;
			res.kind        = KIND_ERROR;
			res.error_code  = err;
			res.track_index = cur_ct;
			phase_d         = PH_HALT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MAGIC;
			fbc_q   <= '0;
			asm_q   <= '0;
			tbl_q   <= '0;
			tot_q   <= '0;
			ct_q    <= '0;
			da_q    <= '0;
			vb_q    <= '0;
			hs_q    <= '0;
			hd_q    <= '0;
			bl_q    <= '0;
			bt_q    <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			fbc_q   <= fbc_d;
			asm_q   <= asm_d;
			tbl_q   <= tbl_d;
			tot_q   <= tot_d;
			ct_q    <= ct_d;
			da_q    <= da_d;
			vb_q    <= vb_d;
			hs_q    <= hs_d;
			hd_q    <= hd_d;
			bl_q    <= bl_d;
			bt_q    <= bt_d;
		end
	end

endmodule

/* src/midi_file_stream_parser_unit.sv */
// channel   | payload   | direction | handshake
// ----------+-----------+-----------+-------------------------
// byte      | byte_t    | in        | byte_valid / byte_stall
// event     | event_t   | out       | event_valid / event_stall
//
// One file byte per cycle while byte_stall is low. A byte is held in the input
// register; when it leaves, the parser state and the result register update
// together, so a result is registered with its last byte, at most one per byte.
// arst_n clears the parser to the header magic and empties both registers.
// event_stall holds the result register; byte_stall rises only when the input
// register is full and the result register cannot move.
module midi_file_stream_parser_unit import smfp_pkg::*; #(
	parameter int unsigned MAX_VARLEN_BYTES = VARLEN_MAX_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   byte_valid,
	output logic   byte_stall,
	input  byte_t  byte_data,
	output logic   event_valid,
	input  logic   event_stall,
	output event_t event_data
);

	logic   valid_s1;
	byte_t  item_s1;
	logic   valid_s2;
	event_t res_s2;
	logic   advance;
	logic   step;
	logic   res_valid;
	event_t res;

	assign advance    = !valid_s2 || !event_stall;
	assign step       = valid_s1 && advance;
	assign byte_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			item_s1 <= byte_data;
		end
	end

	smfp_core #(
		.MAX_VARLEN_BYTES(MAX_VARLEN_BYTES)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.item     (item_s1),
		.res_valid(res_valid),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= step && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			res_s2 <= res;
		end
	end

	assign event_valid = valid_s2;
	assign event_data  = res_s2;

`ifndef SYNTHESIS
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && event_data.kind == KIND_ERROR |-> event_data.error_code != ERR_NONE)
		else $error("error result without error code");
	a_no_code: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && event_data.kind != KIND_ERROR |-> event_data.error_code == ERR_NONE)
		else $error("error code on non-error result");
	a_empty_eot: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && event_data.kind == KIND_EMPTY |-> event_data.track_end)
		else $error("empty track without end of track");
	a_header: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && event_data.kind == KIND_HEADER
		|-> !event_data.track_end && event_data.track_index == 16'd0)
		else $error("header result with track fields set");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> valid_s1 && valid_s2 && event_stall)
		else $error("input stalled while result register free");
`endif

endmodule

/* dv/midi_file_stream_parser_checker.sv */
`timescale 1ns / 1ps

module smfp_parse_checker import smfp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   byte_valid,
	input  logic   byte_stall,
	input  byte_t  byte_data,
	input  logic   event_valid,
	input  logic   event_stall,
	input  event_t event_data,
	output int     fail_count,
	output int     pending,
	output int     results,
	output logic [5:0]  kinds_seen,
	output logic [15:0] codes_seen
);

	typedef enum int {VL_MORE, VL_DONE, VL_OVER} vl_res_t;

	phase_t      ph;
	logic [2:0]  fld_cnt;
	logic [31:0] shift_reg;
	logic [31:0] trk_left;
	logic [15:0] trk_total;
	logic [15:0] trk_cur;
	logic [27:0] delta_acc;
	logic [2:0]  vl_cnt;
	logic [7:0]  st_held;
	logic [7:0]  dat_held;
	logic [27:0] body_rem;
	logic [27:0] body_len;

	bit     nx_hit;
	event_t nx_ev;
	event_t want;
	event_t parsed_events[$];

	function automatic void clear_parser();
		ph = PH_MAGIC;
		fld_cnt = '0;
		shift_reg = '0;
		trk_left = '0;
		trk_total = '0;
		trk_cur = '0;
		delta_acc = '0;
		vl_cnt = '0;
		st_held = '0;
		dat_held = '0;
		body_rem = '0;
		body_len = '0;
	endfunction

	function automatic bit take_field(input logic [7:0] b, input int n);
		shift_reg = {shift_reg[23:0], b};
		fld_cnt = fld_cnt + 3'd1;
		if (fld_cnt >= n) begin
			fld_cnt = '0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic vl_res_t take_varlen(input logic [7:0] b, inout logic [27:0] acc);
		acc = {acc[20:0], b[6:0]};
		vl_cnt = vl_cnt + 3'd1;
		if (!b[7]) begin
			vl_cnt = '0;
			return VL_DONE;
		end
		if (vl_cnt >= VARLEN_MAX_DEF)
			return VL_OVER;
		return VL_MORE;
	endfunction

	function automatic void raise(input logic [3:0] code);
		nx_hit = 1'b1;
		nx_ev.kind = KIND_ERROR;
		nx_ev.error_code = code;
		nx_ev.track_index = trk_cur;
		ph = PH_HALT;
	endfunction

	function automatic void advance_track();
		trk_cur = trk_cur + 16'd1;
		ph = (trk_cur >= trk_total) ? PH_DONE : PH_TMAGIC;
	endfunction

	task automatic parse_byte(input byte_t bi);
		logic [7:0]  b;
		logic [7:0]  d2;
		logic [15:0] v16;
		bit          fin;
		vl_res_t     r;
		b = bi.data_byte;
		d2 = '0;
		fin = 1'b0;
		nx_hit = 1'b0;
		nx_ev = '0;
		if (bi.new_file)
			clear_parser();
		case (ph) inside
		PH_MAGIC: if (take_field(b, 4)) begin
			if (shift_reg != MAGIC_MTHD) raise(ERR_BAD_MTHD);
			else ph = PH_HLEN;
		end
		PH_HLEN: if (take_field(b, 4)) begin
			if (shift_reg != HEADER_LEN) raise(ERR_HDR_LEN);
			else ph = PH_FMT;
		end
		PH_FMT: if (take_field(b, 2)) begin
			v16 = shift_reg[15:0];
			if (v16 == 16'd2) raise(ERR_FORMAT2);
			else if (v16 > 16'd1) raise(ERR_BAD_FORMAT);
			else begin
				dat_held = v16[7:0];
				ph = PH_NTRK;
			end
		end
		PH_NTRK: if (take_field(b, 2)) begin
			trk_total = shift_reg[15:0];
			ph = PH_DIV;
		end
		PH_DIV: if (take_field(b, 2)) begin
			v16 = shift_reg[15:0];
			if (v16[15]) raise(ERR_SMPTE);
			else begin
				nx_hit = 1'b1;
				nx_ev.kind = KIND_HEADER;
				nx_ev.file_format = dat_held[0];
				nx_ev.track_count = trk_total;
				nx_ev.ticks_per_quarter = v16[14:0];
				trk_cur = '0;
				ph = (trk_total != 0) ? PH_TMAGIC : PH_DONE;
			end
		end
		PH_TMAGIC: if (take_field(b, 4)) begin
			if (shift_reg != MAGIC_MTRK) raise(ERR_BAD_MTRK);
			else ph = PH_TLEN;
		end
		PH_TLEN: if (take_field(b, 4)) begin
			trk_left = shift_reg;
			delta_acc = '0;
			vl_cnt = '0;
			if (trk_left == 0) begin
				nx_hit = 1'b1;
				nx_ev.kind = KIND_EMPTY;
				nx_ev.track_end = 1'b1;
				nx_ev.track_index = trk_cur;
				advance_track();
			end else
				ph = PH_DELTA;
		end
		PH_DELTA, PH_STATUS, PH_META_TYPE, PH_BODY_LEN, PH_BODY, PH_DATA1, PH_DATA2: begin
			trk_left = trk_left - 32'd1;
			case (ph)
			PH_DELTA: begin
				r = take_varlen(b, delta_acc);
				if (r == VL_OVER) raise(ERR_VARLEN);
				else if (r == VL_DONE) ph = PH_STATUS;
			end
			PH_STATUS: begin
				st_held = b;
				dat_held = '0;
				body_len = '0;
				vl_cnt = '0;
				if (b == STATUS_META) ph = PH_META_TYPE;
				else if (b == STATUS_SYSEX || b == STATUS_SYSEX_E) ph = PH_BODY_LEN;
				else if (b[7:4] >= 4'h8 && b[7:4] <= 4'hE) ph = PH_DATA1;
				else raise(ERR_BAD_STATUS);
			end
			PH_META_TYPE: begin
				dat_held = b;
				ph = PH_BODY_LEN;
			end
			PH_BODY_LEN: begin
				r = take_varlen(b, body_len);
				if (r == VL_OVER) raise(ERR_VARLEN);
				else if (r == VL_DONE) begin
					if (body_len == 0) fin = 1'b1;
					else begin
						body_rem = body_len;
						ph = PH_BODY;
					end
				end
			end
			PH_BODY: begin
				body_rem = body_rem - 28'd1;
				fin = (body_rem == 0);
			end
			PH_DATA1: begin
				dat_held = b;
				if (st_held[7:4] == 4'hC || st_held[7:4] == 4'hD) fin = 1'b1;
				else ph = PH_DATA2;
			end
			default: begin
				d2 = b;
				fin = 1'b1;
			end
			endcase
			if (nx_hit)
				return;
			if (!fin) begin
				if (trk_left == 0)
					raise(ERR_OVERRUN);
				return;
			end
			nx_hit = 1'b1;
			if (st_held == STATUS_META) begin
				nx_ev.kind = KIND_META;
				nx_ev.body_length = body_len;
			end else if (st_held == STATUS_SYSEX || st_held == STATUS_SYSEX_E) begin
				nx_ev.kind = KIND_SYSEX;
				nx_ev.body_length = body_len;
			end else begin
				nx_ev.kind = KIND_CHANNEL;
				nx_ev.second_data = d2;
			end
			nx_ev.delta_time = delta_acc;
			nx_ev.status_byte = st_held;
			nx_ev.first_data = dat_held;
			nx_ev.track_index = trk_cur;
			nx_ev.track_end = (trk_left == 0);
			delta_acc = '0;
			vl_cnt = '0;
			if (trk_left == 0) advance_track();
			else ph = PH_DELTA;
		end
		default: ;
		endcase
	endtask

	function automatic void cmp(input string name, input logic [31:0] exp_v,
			input logic [31:0] got_v);
		if (exp_v !== got_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, got_v);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_parser();
			parsed_events.delete();
			fail_count = 0;
			results = 0;
			kinds_seen = '0;
			codes_seen = '0;
			pending <= 0;
		end else begin
			if (byte_valid && !byte_stall) begin
				parse_byte(byte_data);
				if (nx_hit)
					parsed_events.push_back(nx_ev);
			end
			if (event_valid && !event_stall) begin
				results++;
				if (parsed_events.size() == 0) begin
					$error("event transfer with nothing predicted: %p", event_data);
					fail_count++;
				end else begin
					want = parsed_events.pop_front();
					cmp("kind", 32'(want.kind), 32'(event_data.kind));
					cmp("delta_time", 32'(want.delta_time), 32'(event_data.delta_time));
					cmp("status_byte", 32'(want.status_byte), 32'(event_data.status_byte));
					cmp("first_data", 32'(want.first_data), 32'(event_data.first_data));
					cmp("second_data", 32'(want.second_data), 32'(event_data.second_data));
					cmp("body_length", 32'(want.body_length), 32'(event_data.body_length));
					cmp("file_format", 32'(want.file_format), 32'(event_data.file_format));
					cmp("track_count", 32'(want.track_count), 32'(event_data.track_count));
					cmp("ticks_per_quarter", 32'(want.ticks_per_quarter),
						32'(event_data.ticks_per_quarter));
					cmp("error_code", 32'(want.error_code), 32'(event_data.error_code));
					cmp("track_end", 32'(want.track_end), 32'(event_data.track_end));
					cmp("track_index", 32'(want.track_index), 32'(event_data.track_index));
					kinds_seen[want.kind] = 1'b1;
					if (want.kind == KIND_ERROR)
						codes_seen[want.error_code] = 1'b1;
				end
			end
			pending <= parsed_events.size();
		end
	end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
	import smfp_pkg::*;

	localparam int LIMIT      = 200000;
	localparam int SETTLE_CYC = 8;
	localparam int RAND_BYTES = 1350;
	localparam int HOLD_CYC   = 400;
	localparam int NUM_SCEN   = 12;

	typedef enum int {
		SC_CLEAN, SC_MAGIC, SC_HLEN, SC_FMT2, SC_FMTX, SC_SMPTE,
		SC_MTRK, SC_STATUS, SC_VARLEN, SC_SHORT, SC_NOISE, SC_CUT
	} scen_t;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   byte_valid = 1'b0;
	logic   byte_stall;
	byte_t  byte_data = '0;
	logic   event_valid;
	logic   event_stall = 1'b0;
	event_t event_data;

	int          fail_count;
	int          pending;
	int          results;
	logic [5:0]  kinds_seen;
	logic [15:0] codes_seen;

	int src_idle = 0;
	int snk_stall = 0;
	int hold_req = 0;
	int hold_ack = 0;
	int hold_left = 0;
	int cycles = 0;
	int sent = 0;

	logic [7:0] fbuf[$];

	midi_file_stream_parser_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data),
		.event_valid(event_valid),
		.event_stall(event_stall),
		.event_data (event_data)
	);

	smfp_parse_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data),
		.event_valid(event_valid),
		.event_stall(event_stall),
		.event_data (event_data),
		.fail_count (fail_count),
		.pending    (pending),
		.results    (results),
		.kinds_seen (kinds_seen),
		.codes_seen (codes_seen)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("[midi_file_stream_parser_unit] ERROR");
			$finish;
		end
	end

	// long hold-off: counted here, requested by the stimulus
	always @(posedge clk) begin
		if (hold_left > 0) begin
			event_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_req != hold_ack) begin
			event_stall <= 1'b1;
			hold_ack <= hold_req;
			hold_left <= HOLD_CYC;
		end else
			event_stall <= ($urandom_range(99) < snk_stall);
	end

	task automatic send_byte(input logic [7:0] d, input logic nf);
		while ($urandom_range(99) < src_idle) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_data <= '{data_byte: d, new_file: nf};
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
		sent++;
	endtask

	task automatic send_file();
		foreach (fbuf[i])
			send_byte(fbuf[i], i == 0);
	endtask

	task automatic wait_idle();
		byte_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic put_be(ref logic [7:0] q[$], input logic [31:0] v, input int n);
		int i;
		for (i = n - 1; i >= 0; i--)
			q.push_back(v[8 * i +: 8]);
	endtask

	// sometimes padded with a redundant leading continuation byte
	task automatic put_vl(ref logic [7:0] q[$], input logic [27:0] v);
		int n;
		int i;
		n = 1;
		while (n < 4 && (v >> (7 * n)) != 0)
			n++;
		if (n < 4 && $urandom_range(4) == 0)
			n++;
		for (i = n - 1; i >= 0; i--)
			q.push_back({i != 0, 7'(v >> (7 * i))});
	endtask

	task automatic add_event(ref logic [7:0] q[$], input scen_t fault);
		logic [7:0]  st;
		logic [27:0] dt;
		int          blen;
		int          pick;
		pick = $urandom_range(9);
		case ($urandom_range(5))
		0: dt = '0;
		1: dt = 28'hFFF_FFFF;
		2: dt = 28'($urandom_range(127));
		3: dt = 28'($urandom);
		default: dt = 28'($urandom_range(16383));
		endcase
		if (fault == SC_VARLEN && pick < 5) begin
			repeat (4) q.push_back(8'h80 | 8'($urandom_range(127)));
			return;
		end
		put_vl(q, dt);
		if (fault == SC_STATUS) begin
			if ($urandom_range(1))
				st = 8'($urandom_range(127));
			else begin
				do st = 8'($urandom_range(8'hF1, 8'hFE));
				while (st == STATUS_SYSEX_E);
			end
			q.push_back(st);
			return;
		end
		if (pick < 6) begin
			st = {4'($urandom_range(4'h8, 4'hE)), 4'($urandom)};
			q.push_back(st);
			q.push_back(8'($urandom));
			if (st[7:4] != 4'hC && st[7:4] != 4'hD)
				q.push_back(8'($urandom));
			return;
		end
		if (pick < 8) begin
			q.push_back(STATUS_META);
			q.push_back($urandom_range(1) ? 8'h2F : 8'($urandom));
		end else
			q.push_back($urandom_range(1) ? STATUS_SYSEX : STATUS_SYSEX_E);
		if (fault == SC_VARLEN) begin
			repeat (4) q.push_back(8'h80 | 8'($urandom_range(127)));
			return;
		end
		blen = $urandom_range(6);
		put_vl(q, 28'(blen));
		repeat (blen) q.push_back(8'($urandom));
	endtask

	task automatic build_file(input scen_t sc);
		logic [7:0]  trk[$];
		logic [15:0] fmt;
		logic [15:0] ntrk;
		logic [15:0] div;
		logic [31:0] tlen;
		int          ntx;
		int          nev;
		int          hit_ev;
		int          k;
		int          t;
		int          e;
		fbuf.delete();
		fmt = 16'($urandom_range(1));
		case ($urandom_range(9))
		0: ntrk = '0;
		1: ntrk = 16'hFFFF;
		2: ntrk = 16'($urandom);
		default: ntrk = 16'($urandom_range(1, 3));
		endcase
		div = {1'b0, 15'($urandom)};
		if ($urandom_range(5) == 0)
			div = $urandom_range(1) ? 16'h7FFF : 16'h0000;
		if (ntrk == 0 && (sc == SC_MTRK || sc == SC_STATUS || sc == SC_VARLEN
				|| sc == SC_SHORT))
			ntrk = 16'd1;
		if (sc == SC_FMT2) fmt = 16'd2;
		if (sc == SC_FMTX) fmt = 16'($urandom_range(3, 16'hFFFF));
		if (sc == SC_SMPTE) div[15] = 1'b1;
		put_be(fbuf, MAGIC_MTHD, 4);
		put_be(fbuf, HEADER_LEN, 4);
		put_be(fbuf, 32'(fmt), 2);
		put_be(fbuf, 32'(ntrk), 2);
		put_be(fbuf, 32'(div), 2);
		if (sc == SC_MAGIC) begin
			k = $urandom_range(3);
			fbuf[k] = fbuf[k] ^ 8'($urandom_range(1, 255));
		end
		if (sc == SC_HLEN) begin
			k = $urandom_range(4, 7);
			fbuf[k] = fbuf[k] ^ 8'($urandom_range(1, 255));
		end
		ntx = (ntrk > 3) ? 3 : ntrk;
		for (t = 0; t < ntx; t++) begin
			trk.delete();
			nev = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 4);
			if (t == 0 && nev == 0 && (sc == SC_STATUS || sc == SC_VARLEN || sc == SC_SHORT))
				nev = 1;
			hit_ev = (nev > 0) ? $urandom_range(nev - 1) : 0;
			for (e = 0; e < nev; e++)
				add_event(trk, (t == 0 && e == hit_ev) ? sc : SC_CLEAN);
			tlen = trk.size();
			if (t == 0 && sc == SC_SHORT)
				tlen = ($urandom_range(3) == 0) ? {4'hF, 28'($urandom)}
					: $urandom_range(1, trk.size() - 1);
			put_be(fbuf, MAGIC_MTRK, 4);
			if (t == 0 && sc == SC_MTRK) begin
				k = fbuf.size() - 1 - $urandom_range(3);
				fbuf[k] = fbuf[k] ^ 8'($urandom_range(1, 255));
			end
			put_be(fbuf, tlen, 4);
			foreach (trk[i])
				fbuf.push_back(trk[i]);
		end
		repeat ($urandom_range(2)) fbuf.push_back(8'($urandom));
		// header faults: little point in streaming the rest
		if (sc == SC_MAGIC || sc == SC_HLEN || sc == SC_FMT2 || sc == SC_FMTX
				|| sc == SC_SMPTE)
			while (fbuf.size() > 15)
				fbuf.pop_back();
	endtask

	initial begin
		scen_t sc;
		int    pass_no;
		int    file_no;
		int    base;
		int    goal;
		int    k;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// bad header magic, then a stray byte the halted parser must drop
		fbuf = '{8'h4D, 8'h54, 8'h68, 8'h65, 8'h00};
		send_file();
		// format 0, zero tracks, widest division, trailing bytes ignored
		fbuf.delete();
		put_be(fbuf, MAGIC_MTHD, 4);
		put_be(fbuf, HEADER_LEN, 4);
		put_be(fbuf, 32'h0000_0000, 4);
		put_be(fbuf, 32'h0000_7FFF, 2);
		fbuf.push_back(8'h90);
		fbuf.push_back(8'h3C);
		send_file();
		wait_idle();

		base = sent;
		file_no = 0;
		for (pass_no = 0; pass_no < 4; pass_no++) begin
			case (pass_no)
			0: begin src_idle = 0;  snk_stall = 0;  end
			1: begin src_idle = 77; snk_stall = 0;  end
			2: begin src_idle = 0;  snk_stall = 77; end
			default: begin src_idle = 38; snk_stall = 38; end
			endcase
			if (pass_no == 0)
				hold_req++;
			goal = base + RAND_BYTES * (pass_no + 1) / 4;
			while (sent < goal) begin
				if (file_no < NUM_SCEN)
					sc = scen_t'(file_no);
				else begin
					k = $urandom_range(23);
					sc = (k < NUM_SCEN) ? scen_t'(k) : SC_CLEAN;
				end
				file_no++;
				case (sc)
				SC_NOISE:
					repeat ($urandom_range(8, 24))
						send_byte(8'($urandom), $urandom_range(7) == 0);
				SC_CUT: begin
					build_file(SC_CLEAN);
					k = $urandom_range(1, fbuf.size());
					while (fbuf.size() > k)
						fbuf.pop_back();
					send_file();
				end
				default: begin
					build_file(sc);
					send_file();
				end
				endcase
			end
			wait_idle();
		end

		$display("%0d bytes in %0d files over four pacing phases, %0d results compared",
			sent, file_no + 2, results);
		$display("result kinds seen %b, error codes seen %b", kinds_seen, codes_seen);
		if (fail_count == 0 && pending == 0)
			$display("[midi_file_stream_parser_unit] OK");
		else
			$display("[midi_file_stream_parser_unit] ERROR");
		$finish;
	end

endmodule

/* filelist.f */
src/smfp_pkg.sv
src/smfp_core.sv
src/midi_file_stream_parser_unit.sv
dv/midi_file_stream_parser_checker.sv
dv/testbench.sv
